### src/assert_macros.svh
// Assertion macros shared by the mp5r RTL.
// Each expects clk_i and rst_ni in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define MP5R_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mp5r: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define MP5R_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mp5r: next-cycle check failed");

`endif

### src/mp5r_pkg.sv
// Shared constants and types for the MP5 face reconstruction pipeline.
// No dependencies; imported by the face datapath, divider and top level.
`default_nettype none

package mp5r_pkg;

  // Configuration port
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned REG_IDX_LSB = 2;
  localparam int unsigned TOL_W       = 16;

  typedef enum logic [0:0] {
    REG_MONOTONE_TOL = 1'b0
  } reg_idx_e;

  // Pipeline shape: eleven register stages; two four-stage divide-by-15 units
  // run inside them, starting at stages DIVA_FIRST and DIVB_FIRST.
  localparam int unsigned PIPE_STAGES = 11;
  localparam int unsigned DIV_STAGES  = 4;
  localparam int unsigned DIVA_FIRST  = 1;
  localparam int unsigned DIVB_FIRST  = 3;

endpackage

`default_nettype wire

### src/mp5r_if.sv
// Valid/ready stream interfaces for stencil items in and face items out.
// Depends on nothing; width follows SAMPLE_BITS.
`default_nettype none

interface mp5r_in_if #(
  parameter int unsigned SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_m2;
  logic signed [SAMPLE_BITS-1:0] sample_m1;
  logic signed [SAMPLE_BITS-1:0] sample_c;
  logic signed [SAMPLE_BITS-1:0] sample_p1;
  logic signed [SAMPLE_BITS-1:0] sample_p2;

  modport source (
    output valid, sample_m2, sample_m1, sample_c, sample_p1, sample_p2,
    input  ready
  );
  modport sink (
    input  valid, sample_m2, sample_m1, sample_c, sample_p1, sample_p2,
    output ready
  );
endinterface

interface mp5r_out_if #(
  parameter int unsigned SAMPLE_BITS = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_face;
  logic signed [SAMPLE_BITS-1:0] right_face;

  modport source (
    output valid, left_face, right_face,
    input  ready
  );
  modport sink (
    input  valid, left_face, right_face,
    output ready
  );
endinterface

`default_nettype wire

### src/mp5r_div15.sv
// Four-stage floor division of a signed word by 15 (remainder, then exact division).
// Uses mp5r_pkg for the stage count. WIDTH must be a multiple of 4, at most 64.
`default_nettype none

module mp5r_div15
  import mp5r_pkg::*;
#(
  parameter int unsigned WIDTH = 40
) (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  logic [WIDTH-1:0]      v_i,
  output logic [WIDTH-1:0]      q_o
);

  localparam int unsigned CHUNKS = (WIDTH + 15) / 16;
  localparam int unsigned CW     = 16 * CHUNKS;
  localparam int unsigned SUMW   = 16 + $clog2(CHUNKS + 1);
  localparam int unsigned NIB    = (SUMW + 3) / 4;
  localparam int unsigned NW     = 4 * NIB;
  localparam int unsigned NSW    = $clog2(NIB * 15 + 1);

  logic [WIDTH-1:0] v1_q;
  logic [3:0]       r1_q, r1_d;
  logic [WIDTH-1:0] z2_q, z2_d;
  logic [WIDTH-1:0] z3_q, z3_d;
  logic [WIDTH-1:0] q4_q, q4_d;

  // v mod 15: 2^16 and 16 are both 1 mod 15, so fold 16-bit chunks, then nibbles.
  always_comb begin
    logic [CW-1:0]   upad;
    logic [SUMW-1:0] csum;
    logic [NW-1:0]   cpad;
    logic [NSW-1:0]  nsum;
    logic [4:0]      t;
    logic [3:0]      ru;
    upad = CW'(v_i);
    csum = '0;
    for (int i = 0; i < CHUNKS; i++) begin
      csum = csum + SUMW'(upad[16*i +: 16]);
    end
    cpad = NW'(csum);
    nsum = '0;
    for (int i = 0; i < NIB; i++) begin
      nsum = nsum + NSW'(cpad[4*i +: 4]);
    end
    t = 5'(nsum >> 4) + 5'(nsum[3:0]);
    if (t >= 5'd15) begin
      t = t - 5'd15;
    end
    if (t == 5'd15) begin
      t = '0;
    end
    ru = t[3:0];
    // negative word: raw bits exceed the value by 2^WIDTH, which is 1 mod 15
    if (v_i[WIDTH-1]) begin
      r1_d = (ru == 4'd0) ? 4'd14 : ru - 4'd1;
    end else begin
      r1_d = ru;
    end
  end

  // y = v - r is a multiple of 15; y * (1 + 16 + ... + 16^15) == -y/15 mod 2^64
  always_comb begin
    logic [WIDTH-1:0] y;
    logic [WIDTH-1:0] t3;
    logic [WIDTH-1:0] t4;
    y    = v1_q - WIDTH'(r1_q);
    z2_d = y + (y << 4);
    t3   = z2_q + (z2_q << 8);
    z3_d = t3 + (t3 << 16);
    t4   = z3_q + (z3_q << 32);
    q4_d = -t4;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      v1_q <= v_i;
      r1_q <= r1_d;
    end
    if (en_i[1]) begin
      z2_q <= z2_d;
    end
    if (en_i[2]) begin
      z3_q <= z3_d;
    end
    if (en_i[3]) begin
      q4_q <= q4_d;
    end
  end

  assign q_o = q4_q;

endmodule

`default_nettype wire

### src/mp5r_face.sv
// One face of the MP5 reconstruction as an eleven-stage datapath.
// Uses mp5r_pkg and two mp5r_div15 units; stage loads come from the top level.
`default_nettype none

module mp5r_face
  import mp5r_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic [PIPE_STAGES-1:0]        en_i,
  input  logic [TOL_W-1:0]              tol_i,
  input  logic signed [SAMPLE_BITS-1:0] s_a_i,
  input  logic signed [SAMPLE_BITS-1:0] s_b_i,
  input  logic signed [SAMPLE_BITS-1:0] s_c_i,
  input  logic signed [SAMPLE_BITS-1:0] s_d_i,
  input  logic signed [SAMPLE_BITS-1:0] s_e_i,
  output logic signed [SAMPLE_BITS-1:0] face_o
);

  // Internal width: room for 92x the sample range, rounded to whole nibbles.
  localparam int unsigned IW = 4 * ((SAMPLE_BITS + 11) / 4);

  typedef logic signed [IW-1:0] word_t;

  localparam word_t KA = word_t'(2);
  localparam word_t KB = word_t'(-13);
  localparam word_t KC = word_t'(47);
  localparam word_t KD = word_t'(27);
  localparam word_t KE = word_t'(-3);

  function automatic word_t sext(input logic signed [SAMPLE_BITS-1:0] x);
    sext = {{(IW-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
  endfunction

  // zero unless same sign and both nonzero; smaller magnitude, y on a tie
  function automatic word_t minmod(input word_t x, input word_t y);
    logic [IW-1:0] magx;
    logic [IW-1:0] magy;
    logic          agree;
    magx  = x[IW-1] ? -x : x;
    magy  = y[IW-1] ? -y : y;
    agree = (x[IW-1] == y[IW-1]) && (x != '0) && (y != '0);
    if (!agree) begin
      minmod = '0;
    end else if (magx < magy) begin
      minmod = x;
    end else begin
      minmod = y;
    end
  endfunction

  function automatic word_t wmin(input word_t x, input word_t y);
    wmin = (x < y) ? x : y;
  endfunction

  function automatic word_t wmax(input word_t x, input word_t y);
    wmax = (x > y) ? x : y;
  endfunction

  // Stage 0: interpolant numerator, differences, curvatures
  word_t num0_q, dc0_q, cb0_q, d2m0_q, d2c0_q, d2p0_q, b0_q, c0_q, d0_q;
  word_t num0_d, dc0_d, cb0_d, d2m0_d, d2c0_d, d2p0_d;

  always_comb begin
    word_t a, b, c, d, e;
    a = sext(s_a_i);
    b = sext(s_b_i);
    c = sext(s_c_i);
    d = sext(s_d_i);
    e = sext(s_e_i);
    num0_d = KA * a + KB * b + KC * c + KD * d + KE * e;
    dc0_d  = d - c;
    cb0_d  = (c - b) <<< 2;
    d2m0_d = a + c - (b <<< 1);
    d2c0_d = b + d - (c <<< 1);
    d2p0_d = c + e - (d <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      num0_q <= num0_d;
      dc0_q  <= dc0_d;
      cb0_q  <= cb0_d;
      d2m0_q <= d2m0_d;
      d2c0_q <= d2c0_d;
      d2p0_q <= d2p0_d;
      b0_q   <= sext(s_b_i);
      c0_q   <= sext(s_c_i);
      d0_q   <= sext(s_d_i);
    end
  end

  // f = floor(num / 60) = floor(floor(num / 4) / 15), ready after stage 4
  logic [IW-1:0] fdiv;

  mp5r_div15 #(
    .WIDTH (IW)
  ) u_div_f (
    .clk_i (clk_i),
    .en_i  (en_i[DIVA_FIRST +: DIV_STAGES]),
    .v_i   (num0_q >>> 2),
    .q_o   (fdiv)
  );

  // Stage 1: monotone bound and first minmod level of the curvatures
  word_t fmp1_q, mpa1_q, mpb1_q, mma1_q, mmb1_q, b1_q, c1_q, d1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      fmp1_q <= c0_q + minmod(dc0_q, cb0_q);
      mpa1_q <= minmod((d2c0_q <<< 2) - d2p0_q, (d2p0_q <<< 2) - d2c0_q);
      mpb1_q <= minmod(d2c0_q, d2p0_q);
      mma1_q <= minmod((d2m0_q <<< 2) - d2c0_q, (d2c0_q <<< 2) - d2m0_q);
      mmb1_q <= minmod(d2c0_q, d2m0_q);
      b1_q   <= b0_q;
      c1_q   <= c0_q;
      d1_q   <= d0_q;
    end
  end

  // Stage 2: limited curvatures and the bound terms, all at twice scale
  word_t x40_2_q, fmd2_q, ful2_q, c2x2_q, d2x2_q, base2_q, fmp2_q, cen2_q;
  word_t x40_2_d, fmd2_d;

  always_comb begin
    word_t dmmp, dmmm;
    dmmp    = minmod(mpa1_q, mpb1_q);
    dmmm    = minmod(mma1_q, mmb1_q);
    // 8*dmmm/3 == 40*dmmm/15, so a second divide-by-15 unit serves
    x40_2_d = (dmmm <<< 5) + (dmmm <<< 3);
    fmd2_d  = c1_q + d1_q - dmmp;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      x40_2_q <= x40_2_d;
      fmd2_q  <= fmd2_d;
      ful2_q  <= (c1_q <<< 1) + ((c1_q - b1_q) <<< 3);
      c2x2_q  <= c1_q <<< 1;
      d2x2_q  <= d1_q <<< 1;
      base2_q <= (c1_q <<< 1) + c1_q - b1_q;
      fmp2_q  <= fmp1_q;
      cen2_q  <= c1_q;
    end
  end

  logic [IW-1:0] qdiv;

  mp5r_div15 #(
    .WIDTH (IW)
  ) u_div_lc (
    .clk_i (clk_i),
    .en_i  (en_i[DIVB_FIRST +: DIV_STAGES]),
    .v_i   (x40_2_q),
    .q_o   (qdiv)
  );

  // Stage 3: partial min/max of the bounds that do not need the curvature term
  word_t loa3_q, hia3_q, mcf3_q, xcf3_q, base3_q, fmp3_q, cen3_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      loa3_q  <= wmin(wmin(c2x2_q, d2x2_q), fmd2_q);
      hia3_q  <= wmax(wmax(c2x2_q, d2x2_q), fmd2_q);
      mcf3_q  <= wmin(c2x2_q, ful2_q);
      xcf3_q  <= wmax(c2x2_q, ful2_q);
      base3_q <= base2_q;
      fmp3_q  <= fmp2_q;
      cen3_q  <= cen2_q;
    end
  end

  // Stage 4: alignment with the interpolant divider
  word_t loa4_q, hia4_q, mcf4_q, xcf4_q, base4_q, fmp4_q, cen4_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      loa4_q  <= loa3_q;
      hia4_q  <= hia3_q;
      mcf4_q  <= mcf3_q;
      xcf4_q  <= xcf3_q;
      base4_q <= base3_q;
      fmp4_q  <= fmp3_q;
      cen4_q  <= cen3_q;
    end
  end

  // Stage 5: test factors, sign agreement and magnitude screen
  word_t              f5_q, loa5_q, hia5_q, mcf5_q, xcf5_q, base5_q;
  logic               same5_q, big5_q, same5_d, big5_d;
  logic [TOL_W-1:0]   pm5_q, qm5_q;
  logic [IW-1:0]      magp, magq;

  always_comb begin
    word_t f, p, q;
    f       = word_t'(fdiv);
    p       = f - cen4_q;
    q       = f - fmp4_q;
    magp    = p[IW-1] ? -p : p;
    magq    = q[IW-1] ? -q : q;
    same5_d = (p[IW-1] == q[IW-1]) && (p != '0) && (q != '0);
    big5_d  = (|magp[IW-1:TOL_W]) || (|magq[IW-1:TOL_W]) ||
              (magp[TOL_W-1:0] > tol_i) || (magq[TOL_W-1:0] > tol_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      f5_q    <= word_t'(fdiv);
      same5_q <= same5_d;
      big5_q  <= big5_d;
      pm5_q   <= magp[TOL_W-1:0];
      qm5_q   <= magq[TOL_W-1:0];
      loa5_q  <= loa4_q;
      hia5_q  <= hia4_q;
      mcf5_q  <= mcf4_q;
      xcf5_q  <= xcf4_q;
      base5_q <= base4_q;
    end
  end

  // Stage 6: test product against the tolerance
  word_t              f6_q, loa6_q, hia6_q, mcf6_q, xcf6_q, base6_q;
  logic               pass6_q;
  logic [2*TOL_W-1:0] prod6;

  assign prod6 = (2*TOL_W)'(pm5_q) * (2*TOL_W)'(qm5_q);

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      pass6_q <= !same5_q || (!big5_q && (prod6 <= (2*TOL_W)'(tol_i)));
      f6_q    <= f5_q;
      loa6_q  <= loa5_q;
      hia6_q  <= hia5_q;
      mcf6_q  <= mcf5_q;
      xcf6_q  <= xcf5_q;
      base6_q <= base5_q;
    end
  end

  // Stage 7: large-curvature bound
  word_t f7_q, loa7_q, hia7_q, mcf7_q, xcf7_q, flc7_q;
  logic  pass7_q;

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      flc7_q  <= base6_q + word_t'(qdiv);
      f7_q    <= f6_q;
      pass7_q <= pass6_q;
      loa7_q  <= loa6_q;
      hia7_q  <= hia6_q;
      mcf7_q  <= mcf6_q;
      xcf7_q  <= xcf6_q;
    end
  end

  // Stage 8: final lower and upper bounds
  word_t f8_q, lo8_q, hi8_q;
  logic  pass8_q;

  always_ff @(posedge clk_i) begin
    if (en_i[8]) begin
      lo8_q   <= wmax(loa7_q, wmin(mcf7_q, flc7_q));
      hi8_q   <= wmin(hia7_q, wmax(xcf7_q, flc7_q));
      f8_q    <= f7_q;
      pass8_q <= pass7_q;
    end
  end

  // Stage 9: distances from the doubled interpolant to the bounds
  word_t f9_q, dl9_q, dh9_q;
  logic  pass9_q;

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      dl9_q   <= lo8_q - (f8_q <<< 1);
      dh9_q   <= hi8_q - (f8_q <<< 1);
      f9_q    <= f8_q;
      pass9_q <= pass8_q;
    end
  end

  // Stage 10: unless the test passed, median clip and halve toward minus infinity; saturate
  logic signed [SAMPLE_BITS-1:0] face10_q, face10_d;

  always_comb begin
    word_t r, v;
    logic  fits;
    r    = (f9_q <<< 1) + minmod(dl9_q, dh9_q);
    v    = pass9_q ? f9_q : (r >>> 1);
    fits = (&v[IW-1:SAMPLE_BITS-1]) || !(|v[IW-1:SAMPLE_BITS-1]);
    if (fits) begin
      face10_d = v[SAMPLE_BITS-1:0];
    end else if (v[IW-1]) begin
      face10_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      face10_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[10]) begin
      face10_q <= face10_d;
    end
  end

  assign face_o = face10_q;

endmodule

`default_nettype wire

### src/mp5_interface_reconstruction_top.sv
// Top level of the MP5 face reconstruction: APB register, stage control, two faces.
// Uses mp5r_pkg, mp5r_if interfaces, mp5r_face and assert_macros.svh.
//
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+-----------------------------------------
//  in_if    | in  | valid / ready        | sample_m2, sample_m1, sample_c, sample_p1, sample_p2
//  out_if   | out | valid / ready        | left_face, right_face
//  apb      | in  | psel, penable, pready| paddr, pwdata -> prdata (monotone_tolerance)
//
// One item per cycle sustained while out_if.ready is high; eleven register stages in all,
// among them the two four-stage divide-by-15 units (interpolant, curvature term).
// Each stage has its own valid bit and takes a new item whenever it is empty or moving,
// so bubbles close up and input is taken while a finished item waits, if any stage is empty.
// Reset clears the stage valid bits and the tolerance; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"

module mp5_interface_reconstruction_top
  import mp5r_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  mp5r_in_if.sink           in_if,
  mp5r_out_if.source        out_if
);

  logic [TOL_W-1:0]       tol_q;
  reg_idx_e               reg_idx;
  logic                   cfg_wr;

  logic [PIPE_STAGES-1:0] vld_q, vld_d;
  logic [PIPE_STAGES-1:0] load;
  logic [PIPE_STAGES-1:0] upv;
  logic [PIPE_STAGES:0]   rdy;

  logic signed [SAMPLE_BITS-1:0] face_l, face_r;

  assign reg_idx = reg_idx_e'(paddr[REG_IDX_LSB]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      REG_MONOTONE_TOL: prdata = APB_DW'(tol_q);
      default:          prdata = '0;
    endcase
  end

  // stage k may load when it is empty or its item moves on this cycle
  always_comb begin
    rdy[PIPE_STAGES] = out_if.ready;
    for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    upv = {vld_q[PIPE_STAGES-2:0], in_if.valid};
    for (int k = 0; k < PIPE_STAGES; k++) begin
      load[k]  = rdy[k] && upv[k];
      vld_d[k] = rdy[k] ? upv[k] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
      vld_q <= '0;
    end else begin
      if (cfg_wr && (reg_idx == REG_MONOTONE_TOL)) begin
        tol_q <= pwdata[TOL_W-1:0];
      end
      vld_q <= vld_d;
    end
  end

  assign in_if.ready = rdy[0];

  // left face runs on the mirrored stencil
  mp5r_face #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_face_left (
    .clk_i  (clk_i),
    .en_i   (load),
    .tol_i  (tol_q),
    .s_a_i  (in_if.sample_p2),
    .s_b_i  (in_if.sample_p1),
    .s_c_i  (in_if.sample_c),
    .s_d_i  (in_if.sample_m1),
    .s_e_i  (in_if.sample_m2),
    .face_o (face_l)
  );

  mp5r_face #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_face_right (
    .clk_i  (clk_i),
    .en_i   (load),
    .tol_i  (tol_q),
    .s_a_i  (in_if.sample_m2),
    .s_b_i  (in_if.sample_m1),
    .s_c_i  (in_if.sample_c),
    .s_d_i  (in_if.sample_p1),
    .s_e_i  (in_if.sample_p2),
    .face_o (face_r)
  );

  assign out_if.valid      = vld_q[PIPE_STAGES-1];
  assign out_if.left_face  = face_l;
  assign out_if.right_face = face_r;

  `MP5R_ASSERT_NEXT(a_accept_fills_first, in_if.valid && in_if.ready, vld_q[0])
  `MP5R_ASSERT_NEXT(a_stalled_out_holds, vld_q[PIPE_STAGES-1] && !out_if.ready, vld_q[PIPE_STAGES-1] && $stable(face_l) && $stable(face_r))
  `MP5R_ASSERT_NEXT(a_tol_written, cfg_wr && (reg_idx == REG_MONOTONE_TOL), tol_q == $past(pwdata[TOL_W-1:0]))
  `MP5R_ASSERT_IMPL(a_full_pipe_blocks, (&vld_q) && !out_if.ready, !in_if.ready)

endmodule

`default_nettype wire
